// ----- hdl/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and constants of the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int PATTERN_WORDS   = 4;
  localparam int BYTES_PER_WORD  = 8;
  localparam int CFG_LEN_W       = 6;

  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN_A      = 3'd0;
  localparam logic [2:0] REG_PATTERN_B      = 3'd1;
  localparam logic [2:0] REG_PATTERN_C      = 3'd2;
  localparam logic [2:0] REG_PATTERN_D      = 3'd3;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd4;

  // per-item control broadcast to every cell
  typedef struct packed {
    logic load;
    logic at_start;
    logic has_byte;
  } wgm_item_t;

  // handed from each cell to the next one up the row
  typedef struct packed {
    logic seed;
    logic old_bit;
    logic new_bit;
  } wgm_link_t;

  typedef struct packed {
    logic matched;
    logic final_result;
  } wgm_result_t;

endpackage

// ----- hdl/wgm_cell.sv -----
// ----------------------------------------------------------------------------
// wgm_cell
// One position of the match row: holds one row bit and its pattern byte test.
// ----------------------------------------------------------------------------
module wgm_cell
  import wgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  wgm_item_t  item,
  input  logic [7:0] text_byte,
  input  logic [7:0] pat_byte,
  input  logic       enable,
  input  wgm_link_t  link_in,
  output wgm_link_t  link_out
);

  logic row_bit;
  logic is_star;
  logic hit;
  logic seed;
  logic eff_old;
  logic upd;
  logic row_bit_next;

  always_comb begin
    is_star = (pat_byte == STAR_CHAR);
    hit     = (pat_byte == text_byte) || (pat_byte == QMARK_CHAR);
    // seed holds while every pattern byte below is a star
    seed    = link_in.seed && enable && is_star;
    eff_old = item.at_start ? seed : row_bit;
    // star takes the row above or the run from the cell below
    if (!enable) begin
      upd = 1'b0;
    end else if (is_star) begin
      upd = eff_old || link_in.new_bit;
    end else begin
      upd = link_in.old_bit && hit;
    end
    row_bit_next = item.has_byte ? upd : eff_old;
    link_out.seed    = seed;
    link_out.old_bit = eff_old;
    link_out.new_bit = row_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bit <= 1'b0;
    end else if (item.load) begin
      row_bit <= row_bit_next;
    end
  end

endmodule

// ----- hdl/wgm_result_fifo.sv -----
// ----------------------------------------------------------------------------
// wgm_result_fifo
// Two-entry result queue between the match row and the result channel.
// ----------------------------------------------------------------------------
module wgm_result_fifo
  import wgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  wgm_result_t push_data,
  output logic        full,
  output logic        valid,
  input  logic        pop,
  output wgm_result_t pop_data
);

  wgm_result_t entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign pop_data = entry[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && valid)) begin
      count_next = count + 2'd1;
    end else if (!push && pop && valid) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full result queue");

  a_drain_last: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1 && pop && !push) |=> !valid)
    else $error("queue not empty after last entry popped");

endmodule

// ----- hdl/wildcard_glob_matcher_top.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_top
// Streams text bytes against a configured glob pattern ('?' any byte, '*' any
// run) and returns one match flag per input item. Every item is handled
// combinationally through a row of PATTERN_MAX cells, each holding one bit of
// the dynamic-programming row; the leading-star seed and the star run both
// ripple up that row within the cycle, so a new item is taken on every clock
// while text_stall is low; cfg_ready is always high. No startup sweep. Results
// wait in a two-entry queue; text_stall rises only while that queue is full.
// The user writes the pattern and its length over the configuration port only
// while no text item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // text channel
  input  logic        text_valid,
  output logic        text_stall,
  input  logic [7:0]  text_byte,
  input  logic        has_byte,
  input  logic        text_end,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        matched,
  output logic        final_result,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int LEN_W = (PATTERN_MAX < 2) ? 1 : $clog2(PATTERN_MAX + 1);

  logic [PATTERN_WORDS-1:0][63:0] pattern_words;
  logic [CFG_LEN_W-1:0]           pattern_length;
  logic [LEN_W-1:0]               eff_len;
  logic                           row0;
  logic                           at_start;
  logic                           accept;
  wgm_item_t                      item;
  wgm_link_t                      link [PATTERN_MAX+1];
  logic [PATTERN_MAX:0]           row_next;
  wgm_result_t                    result_in;
  wgm_result_t                    result_out;
  logic                           fifo_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_words  <= '0;
      pattern_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C, REG_PATTERN_D: begin
          pattern_words[cfg_index[1:0]] <= cfg_data;
        end
        REG_PATTERN_LENGTH: begin
          pattern_length <= cfg_data[CFG_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // lengths above the row size clamp to the full row
  assign eff_len = (pattern_length > CFG_LEN_W'(PATTERN_MAX)) ?
                   LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length);

  assign accept        = text_valid && !text_stall;
  assign text_stall    = fifo_full;
  assign item.load     = accept;
  assign item.at_start = at_start;
  assign item.has_byte = has_byte;

  // position zero: empty pattern prefix
  always_comb begin
    link[0].seed    = 1'b1;
    link[0].old_bit = at_start ? 1'b1 : row0;
    link[0].new_bit = has_byte ? 1'b0 : link[0].old_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row0     <= 1'b1;
      at_start <= 1'b1;
    end else if (accept) begin
      row0     <= link[0].new_bit;
      at_start <= text_end;
    end
  end

  generate
    for (genvar j = 1; j <= PATTERN_MAX; j++) begin : g_cell
      wgm_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .item      (item),
        .text_byte (text_byte),
        .pat_byte  (pattern_words[(j-1)/BYTES_PER_WORD][((j-1)%BYTES_PER_WORD)*8 +: 8]),
        .enable    (eff_len >= LEN_W'(j)),
        .link_in   (link[j-1]),
        .link_out  (link[j])
      );
    end
    for (genvar k = 0; k <= PATTERN_MAX; k++) begin : g_row
      assign row_next[k] = link[k].new_bit;
    end
  endgenerate

  assign result_in.matched      = row_next[eff_len];
  assign result_in.final_result = text_end;

  wgm_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result_in),
    .full      (fifo_full),
    .valid     (result_valid),
    .pop       (!result_stall),
    .pop_data  (result_out)
  );

  assign matched      = result_out.matched;
  assign final_result = result_out.final_result;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("no result after a text transfer");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && text_end) |=> at_start)
    else $error("text end did not rearm the seed");

  a_prefix_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && has_byte) |=> !row0)
    else $error("empty prefix still set after a byte");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives text items and pattern settings into the wildcard glob matcher and
// checks every match flag against a bit-level model of the matching row,
// under random gaps on the text side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import wgm_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [7:0] CH_A = "a";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = '0;
  logic        has_byte = 1'b0;
  logic        text_end = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        matched;
  logic        final_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // matcher model: pattern registers, row and start-of-text flag
  logic [63:0] pat_words [PATTERN_WORDS];
  logic [5:0]  pat_len_reg;
  logic [32:0] glob_row;
  logic        glob_fresh;

  wgm_result_t match_expect_q [$];
  wgm_result_t result_want;
  int          items_sent = 0;
  int          results_seen = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          quiet_mode = 1'b0;

  wildcard_glob_matcher_top dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .has_byte     (has_byte),
    .text_end     (text_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .matched      (matched),
    .final_result (final_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic int active_len();
    return (pat_len_reg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len_reg);
  endfunction

  function automatic wgm_result_t predict_match(logic [7:0] c, logic has, logic fin);
    wgm_result_t r;
    logic [255:0] flat;
    logic [32:0]  nrow;
    logic [7:0]   p;
    logic         chain;
    int           len;
    flat = {pat_words[3], pat_words[2], pat_words[1], pat_words[0]};
    len = active_len();
    // leading stars of the pattern can already match the empty text
    if (glob_fresh) begin
      glob_row = 33'd1;
      chain = 1'b1;
      for (int j = 1; j <= len; j++) begin
        chain = chain && (flat[(j - 1) * 8 +: 8] == STAR_CHAR);
        glob_row[j] = chain;
      end
      glob_fresh = 1'b0;
    end
    if (has) begin
      nrow = '0;
      for (int j = 1; j <= len; j++) begin
        p = flat[(j - 1) * 8 +: 8];
        if (p == STAR_CHAR) begin
          nrow[j] = glob_row[j] | nrow[j - 1];
        end else begin
          nrow[j] = glob_row[j - 1] && (p == c || p == QMARK_CHAR);
        end
      end
      glob_row = nrow;
    end
    r.matched = glob_row[len];
    r.final_result = fin;
    if (fin) glob_fresh = 1'b1;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (match_expect_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected", results_seen));
      end else begin
        result_want = match_expect_q.pop_front();
        if (matched !== result_want.matched)
          report_mismatch($sformatf("result %0d matched got %b want %b",
                                    results_seen, matched, result_want.matched));
        if (final_result !== result_want.final_result)
          report_mismatch($sformatf("result %0d final_result got %b want %b",
                                    results_seen, final_result, result_want.final_result));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      stall_left = idle_len() - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_item(logic [7:0] c, logic has, logic fin);
    int gap;
    gap = (!quiet_mode && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= c;
    has_byte   <= has;
    text_end   <= fin;
    do @(posedge clk); while (text_stall);
    match_expect_q.push_back(predict_match(c, has, fin));
    items_sent++;
  endtask

  task automatic drain_results();
    text_valid <= 1'b0;
    while (match_expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register writes only go in once the matcher has nothing in flight
  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PATTERN_A:      pat_words[0] = data;
      REG_PATTERN_B:      pat_words[1] = data;
      REG_PATTERN_C:      pat_words[2] = data;
      REG_PATTERN_D:      pat_words[3] = data;
      REG_PATTERN_LENGTH: pat_len_reg = data[CFG_LEN_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // byte 0 of the pattern is the rightmost character of a string literal
  task automatic load_pattern(logic [255:0] pat, logic [63:0] len_word);
    cfg_write(REG_PATTERN_A, pat[63:0]);
    cfg_write(REG_PATTERN_B, pat[127:64]);
    cfg_write(REG_PATTERN_C, pat[191:128]);
    cfg_write(REG_PATTERN_D, pat[255:192]);
    cfg_write(REG_PATTERN_LENGTH, len_word);
  endtask

  function automatic logic [255:0] random_pattern();
    logic [255:0] pat;
    int mode;
    int lead;
    mode = $urandom_range(0, 4);
    lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    for (int k = 0; k < 32; k++) begin
      if (mode == 0) begin
        pat[k * 8 +: 8] = 8'($urandom);
      end else begin
        case ($urandom_range(0, 5))
          0:       pat[k * 8 +: 8] = STAR_CHAR;
          1:       pat[k * 8 +: 8] = QMARK_CHAR;
          2, 3:    pat[k * 8 +: 8] = CH_A;
          default: pat[k * 8 +: 8] = CH_A + 8'd1;
        endcase
      end
      if (k < lead) pat[k * 8 +: 8] = STAR_CHAR;
    end
    return pat;
  endfunction

  // open_text leaves the text unfinished so the next pattern applies mid-text
  task automatic send_random_text(logic [255:0] pat, int len, bit open_text);
    logic [7:0] txt [$];
    logic [7:0] p;
    int style;
    int n;
    style = $urandom_range(0, 9);
    if (style < 5) begin
      // mostly follows the pattern, sometimes with one byte spoiled
      for (int k = 0; k < len; k++) begin
        p = pat[k * 8 +: 8];
        if (p == STAR_CHAR)
          repeat ($urandom_range(0, 3)) txt.push_back(CH_A + 8'($urandom_range(0, 1)));
        else if (p == QMARK_CHAR)
          txt.push_back(8'($urandom));
        else
          txt.push_back(p);
      end
      if (txt.size() > 0 && $urandom_range(0, 3) == 0)
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
    end else if (style < 8) begin
      n = $urandom_range(0, 10);
      repeat (n) txt.push_back(CH_A + 8'($urandom_range(0, 1)));
    end else begin
      n = $urandom_range(0, 6);
      repeat (n) txt.push_back(8'($urandom));
    end
    if (txt.size() == 0 && !open_text) send_item(8'($urandom), 1'b0, 1'b1);
    foreach (txt[k]) begin
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(txt[k], 1'b1, !open_text && k == txt.size() - 1);
    end
  endtask

  task automatic test_reset_state();
    // empty pattern right after reset: only the empty text matches
    send_item(8'($urandom), 1'b0, 1'b1);
    send_item("z", 1'b1, 1'b1);
  endtask

  task automatic test_directed_patterns();
    logic [255:0] pat;
    load_pattern("*c?a", 64'd4);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b0);
    send_item("x", 1'b1, 1'b1);
    // star-only pattern with a byte beyond the length
    load_pattern("q**", 64'd2);
    send_item(8'($urandom), 1'b0, 1'b1);
    // length above the maximum, extreme byte values, empty item mid-text
    pat = '0;
    for (int k = 0; k < 30; k++) pat[k * 8 +: 8] = STAR_CHAR;
    pat[30 * 8 +: 8] = 8'h00;
    pat[31 * 8 +: 8] = 8'hFF;
    load_pattern(pat, 64'd63);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'($urandom), 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    for (int k = 0; k < 32; k++) pat[k * 8 +: 8] = STAR_CHAR;
    load_pattern(pat, 64'd32);
    send_item(8'($urandom), 1'b0, 1'b1);
    send_item(8'h55, 1'b1, 1'b1);
    load_pattern("?", 64'd1);
    send_item(8'($urandom), 1'b0, 1'b1);
    send_item(8'hAA, 1'b1, 1'b1);
  endtask

  task automatic test_pattern_change();
    load_pattern("ba", 64'd2);
    send_item("a", 1'b1, 1'b0);
    // row keeps its bits, the rest of the text sees the new pattern
    load_pattern("c?", 64'd2);
    send_item("c", 1'b1, 1'b1);
    for (int k = REG_PATTERN_LENGTH + 1; k < (1 << $bits(cfg_index)); k++)
      cfg_write(3'(k), {$urandom, $urandom});
    send_item("q", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [255:0] pat;
    logic [63:0]  len_word;
    int stop_at;
    int phase_end;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      quiet_mode = ($urandom_range(0, 4) == 0);
      len_word = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0:       len_word[5:0] = '0;
        1:       len_word[5:0] = 6'(PATTERN_MAX_DEF);
        2:       len_word[5:0] = 6'($urandom_range(PATTERN_MAX_DEF + 1, 63));
        3:       len_word[5:0] = 6'($urandom_range(0, PATTERN_MAX_DEF));
        default: len_word[5:0] = 6'($urandom_range(1, 8));
      endcase
      if ($urandom_range(0, 3) == 0)
        cfg_write(REG_PATTERN_LENGTH, len_word);
      else
        load_pattern(random_pattern(), len_word);
      if ($urandom_range(0, 5) == 0)
        cfg_write(3'(REG_PATTERN_LENGTH + 1 + $urandom_range(0, 2)), {$urandom, $urandom});
      pat = {pat_words[3], pat_words[2], pat_words[1], pat_words[0]};
      phase_end = items_sent + $urandom_range(40, 90);
      while (items_sent < phase_end) begin
        send_random_text(pat, active_len(), 1'b0);
        if ($urandom_range(0, 19) == 0) drain_results();
      end
      if ($urandom_range(0, 3) == 0) send_random_text(pat, active_len(), 1'b1);
      drain_results();
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    for (int w = 0; w < PATTERN_WORDS; w++) pat_words[w] = '0;
    pat_len_reg = '0;
    glob_row = 33'd1;
    glob_fresh = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed_patterns();
    test_pattern_change();
    test_random_streams();
    drain_results();
    repeat (8) @(posedge clk);
    if (match_expect_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", match_expect_q.size()));
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
